// File: rtl/core/ptwa_pkg.sv
// ptwa_pkg: shared types and constants for the trimmed window average block
// no dependencies; used by the channel interfaces and the top level

package ptwa_pkg;

  // payload widths fixed by the field definitions
  localparam int unsigned ADC_W     = 12;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned OFFSET_W  = 30;
  localparam int unsigned SUM_OUT_W = 18;
  localparam int unsigned PH_W      = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] REG_PH_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PH_OFFSET = CFG_IDX_W'(1);

  localparam logic [GAIN_W-1:0]   PH_GAIN_RST   = GAIN_W'(-77981);
  localparam logic [OFFSET_W-1:0] PH_OFFSET_RST = OFFSET_W'(264563274);

  // q8.8 result: drop 16 fraction bits of the q.24 sum, 17 quotient bits
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned QUO_W      = 17;

  localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = '1;
  localparam logic [PH_W-1:0]      PH_MAX      = {1'b0, {(PH_W-1){1'b1}}};
  localparam logic [PH_W-1:0]      PH_MIN      = {1'b1, {(PH_W-1){1'b0}}};

  typedef logic [ADC_W-1:0]     adc_sample_t;
  typedef logic [SUM_OUT_W-1:0] trimmed_sum_t;
  typedef logic [PH_W-1:0]      ph_value_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM_LO,
    ST_TRIM_HI,
    ST_MUL,
    ST_ADD,
    ST_ROUND,
    ST_PREP,
    ST_DIV,
    ST_REM,
    ST_FIN
  } state_e;

endpackage

// File: rtl/core/ptwa_sample_if.sv
// ptwa_sample_if: valid/ready channel carrying one adc sample per transfer
// depends on ptwa_pkg

interface ptwa_sample_if;
  logic                  valid;
  logic                  ready;
  ptwa_pkg::adc_sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// File: rtl/core/ptwa_result_if.sv
// ptwa_result_if: valid/ready channel carrying trimmed sum and ph per transfer
// depends on ptwa_pkg

interface ptwa_result_if;
  logic                   valid;
  logic                   ready;
  ptwa_pkg::trimmed_sum_t trimmed_sum;
  ptwa_pkg::ph_value_t    ph_value;

  modport source (output valid, output trimmed_sum, output ph_value, input ready);
  modport sink   (input valid, input trimmed_sum, input ph_value, output ready);
endinterface

// File: rtl/core/ph_trimmed_window_average.sv
// samples are taken one at a time: a new one is accepted only once the last result is loaded,
//   the pace set by the scan of the ring through its single read port; an unread result
//   holds the block in its last state
// reset: ring entries read as zero through per-entry valid bits, write pointer
//   zero, gain and offset at their defaults; no clearing pass
// depends on ptwa_pkg, ptwa_sample_if, ptwa_result_if

module ph_trimmed_window_average #(
  parameter int unsigned WINDOW_DEPTH = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ptwa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptwa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  ptwa_sample_if.sink                        sample_i,
  ptwa_result_if.source                      result_o
);

  localparam int unsigned ADRW = $clog2(WINDOW_DEPTH);
  localparam int unsigned IDXW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW   = $clog2(WINDOW_DEPTH * ((1 << ptwa_pkg::ADC_W) - 1) + 1);
  localparam int unsigned CW   = $clog2(WINDOW_DEPTH - 1);
  localparam int unsigned GPW  = ptwa_pkg::GAIN_W + SW + 1;
  localparam int unsigned OPW  = ptwa_pkg::OFFSET_W + CW + 1;
  localparam int unsigned AW   = ((GPW > OPW) ? GPW : OPW) + 2;
  localparam int unsigned TW   = (SW > ptwa_pkg::SUM_OUT_W) ? SW : ptwa_pkg::SUM_OUT_W;

  // divisor is the trimmed entry count; exact reciprocal for dividends below DIVR << QUO_W
  localparam int unsigned DIVR = WINDOW_DEPTH - 2;
  localparam int unsigned DLW  = $clog2(DIVR);
  localparam int unsigned XW   = DLW + ptwa_pkg::QUO_W;
  localparam int unsigned RSH  = XW + DLW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(DIVR) - 64'd1) / 64'(DIVR);
  localparam logic [XW:0] RECIP = (XW+1)'(RECIP_L);

  localparam logic [ADRW-1:0]       LAST_ADR = ADRW'(WINDOW_DEPTH - 1);
  localparam logic [IDXW-1:0]       DEPTH_I  = IDXW'(WINDOW_DEPTH);
  localparam logic signed [OPW-1:0] CNT_S    = OPW'(WINDOW_DEPTH - 2);
  localparam logic [AW-1:0]         ROUND_C  =
    AW'(WINDOW_DEPTH - 2) << (ptwa_pkg::FRAC_SHIFT - 1);
  localparam logic [AW-1:0]         OVF_LIM  = AW'(DIVR) << ptwa_pkg::QUO_W;

  // configuration registers
  logic [ptwa_pkg::GAIN_W-1:0]   ph_gain_q;
  logic [ptwa_pkg::OFFSET_W-1:0] ph_offset_q;

  // sequencer and datapath
  ptwa_pkg::state_e state_q, state_d;
  logic [IDXW-1:0]              idx_q, idx_d;
  logic [AW-1:0]                acc_q, acc_d;
  logic [ptwa_pkg::ADC_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic signed [GPW-1:0]        gp_q, gp_d;
  logic signed [OPW-1:0]        op_q, op_d;
  logic [ptwa_pkg::SUM_OUT_W-1:0] trim_q, trim_d;
  logic [ptwa_pkg::QUO_W-1:0]   quo_q, quo_d;
  logic                         neg_q, neg_d, ovf_q, ovf_d;

  // ring memory and its valid bits
  logic [ptwa_pkg::ADC_W-1:0] ring_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]    ring_vld_q;
  logic [ADRW-1:0]            wptr_q;
  logic [ptwa_pkg::ADC_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic                       take_q;
  logic                       wr_en, rd_en;
  logic [ADRW-1:0]            rd_addr;
  logic [ptwa_pkg::ADC_W-1:0] cur_v;

  // shared adder
  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub;

  // output register
  logic                           out_valid_q;
  logic [ptwa_pkg::SUM_OUT_W-1:0] out_sum_q;
  logic [ptwa_pkg::PH_W-1:0]      out_ph_q;
  logic [ptwa_pkg::PH_W-1:0]      ph_d;
  logic                           load_out;
  logic                           sample_ready;

  logic signed [GPW-1:0] gain_prod;
  logic signed [OPW-1:0] ofs_prod;
  logic [TW-1:0]         trim_ext;
  logic [ptwa_pkg::SUM_OUT_W-1:0] trim_sat;
  logic signed [AW-1:0]  t_shift;
  logic [ptwa_pkg::QUO_W:0] negmag;
  logic [2*XW:0]         recip_prod;
  logic [XW-1:0]         quo_mul;

  assign rd_addr = idx_q[ADRW-1:0];
  assign cur_v   = rd_vld_q ? rd_data_q : '0;
  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

  assign gain_prod = GPW'($signed(ph_gain_q)) * $signed(GPW'({1'b0, acc_q[SW-1:0]}));
  assign ofs_prod  = OPW'($signed(ph_offset_q)) * CNT_S;
  assign trim_ext  = TW'(acc_q[SW-1:0]);
  assign trim_sat  = (trim_ext > TW'(ptwa_pkg::SUM_OUT_MAX)) ? ptwa_pkg::SUM_OUT_MAX
                                                             : trim_ext[ptwa_pkg::SUM_OUT_W-1:0];
  assign t_shift   = $signed(acc_q) >>> ptwa_pkg::FRAC_SHIFT;

  assign recip_prod = (2*XW+1)'(acc_q[XW-1:0]) * (2*XW+1)'(RECIP);
  assign quo_mul    = XW'(quo_q) * XW'(DIVR);

  // floor of a negative quotient: one more in magnitude when a remainder is left
  assign negmag = {1'b0, quo_q} + (ptwa_pkg::QUO_W+1)'(acc_q != '0);

  always_comb begin
    if (ovf_q) begin
      ph_d = neg_q ? ptwa_pkg::PH_MIN : ptwa_pkg::PH_MAX;
    end else if (neg_q) begin
      if (negmag > (ptwa_pkg::QUO_W+1)'(ptwa_pkg::PH_MIN)) begin
        ph_d = ptwa_pkg::PH_MIN;
      end else begin
        ph_d = ptwa_pkg::PH_W'((ptwa_pkg::QUO_W+1)'(0) - negmag);
      end
    end else if (quo_q > ptwa_pkg::QUO_W'(ptwa_pkg::PH_MAX)) begin
      ph_d = ptwa_pkg::PH_MAX;
    end else begin
      ph_d = quo_q[ptwa_pkg::PH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_gain_q   <= ptwa_pkg::PH_GAIN_RST;
      ph_offset_q <= ptwa_pkg::PH_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptwa_pkg::REG_PH_GAIN:   ph_gain_q   <= cfg_data_i[ptwa_pkg::GAIN_W-1:0];
        ptwa_pkg::REG_PH_OFFSET: ph_offset_q <= cfg_data_i[ptwa_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    acc_d        = acc_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    gp_d         = gp_q;
    op_d         = op_q;
    trim_d       = trim_q;
    quo_d        = quo_q;
    neg_d        = neg_q;
    ovf_d        = ovf_q;
    sample_ready = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    load_out     = 1'b0;
    alu_a        = acc_q;
    alu_b        = '0;
    alu_sub      = 1'b0;
    case (state_q)
      ptwa_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_i.valid) begin
          wr_en   = 1'b1;
          idx_d   = '0;
          acc_d   = '0;
          lo_d    = '1;
          hi_d    = '0;
          state_d = ptwa_pkg::ST_SCAN;
        end
      end
      ptwa_pkg::ST_SCAN: begin
        rd_en = (idx_q < DEPTH_I);
        if (take_q) begin
          alu_b = AW'(cur_v);
          acc_d = alu_res;
          if (cur_v < lo_q) lo_d = cur_v;
          if (cur_v > hi_q) hi_d = cur_v;
        end
        if (rd_en) begin
          idx_d = idx_q + IDXW'(1);
        end else begin
          state_d = ptwa_pkg::ST_TRIM_LO;
        end
      end
      ptwa_pkg::ST_TRIM_LO: begin
        alu_b   = AW'(lo_q);
        alu_sub = 1'b1;
        acc_d   = alu_res;
        state_d = ptwa_pkg::ST_TRIM_HI;
      end
      ptwa_pkg::ST_TRIM_HI: begin
        alu_b   = AW'(hi_q);
        alu_sub = 1'b1;
        acc_d   = alu_res;
        state_d = ptwa_pkg::ST_MUL;
      end
      ptwa_pkg::ST_MUL: begin
        gp_d    = gain_prod;
        op_d    = ofs_prod;
        trim_d  = trim_sat;
        state_d = ptwa_pkg::ST_ADD;
      end
      ptwa_pkg::ST_ADD: begin
        alu_a   = AW'(gp_q);
        alu_b   = AW'(op_q);
        acc_d   = alu_res;
        state_d = ptwa_pkg::ST_ROUND;
      end
      ptwa_pkg::ST_ROUND: begin
        // half of the divisor for round to nearest, ties upward
        alu_b   = ROUND_C;
        acc_d   = alu_res;
        state_d = ptwa_pkg::ST_PREP;
      end
      ptwa_pkg::ST_PREP: begin
        // magnitude of the shifted numerator
        alu_a   = '0;
        alu_b   = t_shift;
        alu_sub = acc_q[AW-1];
        acc_d   = alu_res;
        neg_d   = acc_q[AW-1];
        ovf_d   = 1'b0;
        quo_d   = '0;
        state_d = ptwa_pkg::ST_DIV;
      end
      ptwa_pkg::ST_DIV: begin
        // quotient from the reciprocal, overflow from one compare on the adder
        alu_b   = OVF_LIM;
        alu_sub = 1'b1;
        ovf_d   = !alu_res[AW-1];
        quo_d   = recip_prod[RSH +: ptwa_pkg::QUO_W];
        state_d = ptwa_pkg::ST_REM;
      end
      ptwa_pkg::ST_REM: begin
        // remainder, only needed to tell whether the division was exact
        alu_b   = AW'(quo_mul);
        alu_sub = 1'b1;
        acc_d   = alu_res;
        state_d = ptwa_pkg::ST_FIN;
      end
      ptwa_pkg::ST_FIN: begin
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = ptwa_pkg::ST_IDLE;
        end
      end
      default: state_d = ptwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptwa_pkg::ST_IDLE;
      idx_q       <= '0;
      wptr_q      <= '0;
      ring_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      neg_q   <= neg_d;
      take_q  <= rd_en;
      if (wr_en) begin
        ring_vld_q[wptr_q] <= 1'b1;
        wptr_q             <= (wptr_q == LAST_ADR) ? '0 : wptr_q + ADRW'(1);
      end
      if (rd_en) rd_vld_q <= ring_vld_q[rd_addr];
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) ring_q[wptr_q] <= sample_i.adc_sample;
    if (rd_en) rd_data_q <= ring_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    gp_q   <= gp_d;
    op_q   <= op_d;
    trim_q <= trim_d;
    quo_q  <= quo_d;
    if (load_out) begin
      out_sum_q <= trim_q;
      out_ph_q  <= ph_d;
    end
  end

  assign sample_i.ready       = sample_ready;
  assign result_o.valid       = out_valid_q;
  assign result_o.trimmed_sum = out_sum_q;
  assign result_o.ph_value    = out_ph_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> (state_q == ptwa_pkg::ST_SCAN && idx_q == '0))
    else $error("sample transfer did not start a window scan");

  a_wptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q <= LAST_ADR)
    else $error("write pointer beyond window");

  a_extremes_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptwa_pkg::ST_TRIM_LO) |-> (lo_q <= hi_q))
    else $error("window minimum above maximum after scan");

  a_trim_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptwa_pkg::ST_MUL) |-> !acc_q[AW-1])
    else $error("trimmed sum went negative");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptwa_pkg::ST_FIN && !ovf_q) |-> (acc_q < AW'(DIVR)))
    else $error("division remainder out of bounds");

endmodule

// File: sim/tb_ph_trimmed_window_average.sv
// testbench for ph_trimmed_window_average: directed and random pH samples checked
// against an in-bench trimmed moving-window predictor, with random stalls on both sides
// depends on ptwa_pkg, ptwa_sample_if, ptwa_result_if and the block itself
`timescale 1ns / 100ps

module tb_ph_trimmed_window_average;

  localparam int WINDOW_DEPTH = 40;
  localparam int LATENCY      = WINDOW_DEPTH + 10;
  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic [ptwa_pkg::CFG_IDX_W-1:0] REG_SPARE_A = ptwa_pkg::CFG_IDX_W'(2);
  localparam logic [ptwa_pkg::CFG_IDX_W-1:0] REG_SPARE_B = ptwa_pkg::CFG_IDX_W'(3);

  localparam logic [ptwa_pkg::GAIN_W-1:0]   GAIN_MAX   =
    {1'b0, {(ptwa_pkg::GAIN_W-1){1'b1}}};
  localparam logic [ptwa_pkg::GAIN_W-1:0]   GAIN_MIN   =
    {1'b1, {(ptwa_pkg::GAIN_W-1){1'b0}}};
  localparam logic [ptwa_pkg::OFFSET_W-1:0] OFFSET_MAX =
    {1'b0, {(ptwa_pkg::OFFSET_W-1){1'b1}}};
  localparam logic [ptwa_pkg::OFFSET_W-1:0] OFFSET_MIN =
    {1'b1, {(ptwa_pkg::OFFSET_W-1){1'b0}}};

  typedef struct packed {
    ptwa_pkg::trimmed_sum_t trimmed_sum;
    ptwa_pkg::ph_value_t    ph_value;
  } ph_reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [ptwa_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ptwa_pkg::CFG_DATA_W-1:0] cfg_data;

  ptwa_sample_if sample_if ();
  ptwa_result_if result_if ();

  ph_trimmed_window_average #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state, mirrors the block after reset
  ptwa_pkg::adc_sample_t      window_mdl [WINDOW_DEPTH] = '{default: '0};
  int unsigned                write_pos_mdl = 0;
  logic signed [ptwa_pkg::GAIN_W-1:0]   gain_mdl   = ptwa_pkg::PH_GAIN_RST;
  logic signed [ptwa_pkg::OFFSET_W-1:0] offset_mdl = ptwa_pkg::PH_OFFSET_RST;

  ph_reading_t pending_readings [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  ptwa_pkg::adc_sample_t probe_level = 12'd2048;
  ptwa_pkg::adc_sample_t last_sample = '0;

  function automatic ph_reading_t compute_ph_reading(ptwa_pkg::adc_sample_t s);
    ph_reading_t r;
    longint wsum, lo, hi, trimmed, num, den, n, d, q;
    window_mdl[write_pos_mdl] = s;
    write_pos_mdl = (write_pos_mdl == WINDOW_DEPTH - 1) ? 0 : write_pos_mdl + 1;
    wsum = 0;
    lo   = 4095;
    hi   = 0;
    foreach (window_mdl[i]) begin
      wsum += window_mdl[i];
      if (window_mdl[i] < lo) lo = window_mdl[i];
      if (window_mdl[i] > hi) hi = window_mdl[i];
    end
    // only one copy of the minimum and of the maximum goes
    trimmed = wsum - lo - hi;
    num = longint'(gain_mdl) * trimmed + longint'(offset_mdl) * (WINDOW_DEPTH - 2);
    den = longint'(WINDOW_DEPTH - 2) << ptwa_pkg::FRAC_SHIFT;
    // round to nearest, ties upwards: floor((2n + d) / 2d)
    n = 2 * num + den;
    d = 2 * den;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    r.trimmed_sum = (trimmed > ptwa_pkg::SUM_OUT_MAX) ? ptwa_pkg::SUM_OUT_MAX
                                                      : ptwa_pkg::trimmed_sum_t'(trimmed);
    if (q > 32767) r.ph_value = ptwa_pkg::PH_MAX;
    else if (q < -32768) r.ph_value = ptwa_pkg::PH_MIN;
    else r.ph_value = ptwa_pkg::ph_value_t'(q);
    return r;
  endfunction

  // mostly a slowly drifting probe level with noise, plus jumps, rails, repeats and bit flips
  function automatic ptwa_pkg::adc_sample_t draw_sample();
    int unsigned pick;
    int lvl;
    pick = $urandom_range(99);
    if (pick < 50) begin
      if ($urandom_range(15) == 0) probe_level = ptwa_pkg::adc_sample_t'($urandom_range(4095));
      lvl = int'(probe_level) + int'($urandom_range(40)) - 20;
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
      return ptwa_pkg::adc_sample_t'(lvl);
    end else if (pick < 70) begin
      return ptwa_pkg::adc_sample_t'($urandom_range(4095));
    end else if (pick < 80) begin
      return $urandom_range(1) ? '1 : '0;
    end else if (pick < 90) begin
      return last_sample;
    end
    return probe_level ^ (ptwa_pkg::adc_sample_t'(1) << $urandom_range(ptwa_pkg::ADC_W - 1));
  endfunction

  task automatic send_sample(input ptwa_pkg::adc_sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.adc_sample <= s;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    pending_readings.push_back(compute_ph_reading(s));
    last_sample = s;
  endtask

  // hold the sender until every reading has come back, then let the block settle
  task automatic quiesce();
    sample_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ptwa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ptwa_pkg::CFG_DATA_W-1:0] word);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= word;
    @(posedge clk_i);
    case (idx)
      ptwa_pkg::REG_PH_GAIN:   gain_mdl = word[ptwa_pkg::GAIN_W-1:0];
      ptwa_pkg::REG_PH_OFFSET: offset_mdl = word[ptwa_pkg::OFFSET_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic retune_probe();
    logic [ptwa_pkg::GAIN_W-1:0]     gain;
    logic [ptwa_pkg::OFFSET_W-1:0]   offset;
    logic [ptwa_pkg::CFG_DATA_W-1:0] word;
    case ($urandom_range(5))
      0: begin
        gain   = ptwa_pkg::PH_GAIN_RST;
        offset = ptwa_pkg::PH_OFFSET_RST;
      end
      1: begin
        gain   = ptwa_pkg::PH_GAIN_RST + ptwa_pkg::GAIN_W'($urandom_range(16000))
                 - ptwa_pkg::GAIN_W'(8000);
        offset = ptwa_pkg::PH_OFFSET_RST + ptwa_pkg::OFFSET_W'($urandom_range(1 << 25))
                 - ptwa_pkg::OFFSET_W'(1 << 24);
      end
      2: begin
        gain   = ptwa_pkg::GAIN_W'($urandom);
        offset = ptwa_pkg::OFFSET_W'($urandom);
      end
      3: begin
        gain   = $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
        offset = $urandom_range(1) ? OFFSET_MAX : OFFSET_MIN;
      end
      default: begin
        gain   = ptwa_pkg::GAIN_W'($urandom_range(2000)) - ptwa_pkg::GAIN_W'(1000);
        offset = ptwa_pkg::OFFSET_W'($urandom);
      end
    endcase
    // junk above bit 23 of the gain word must be dropped
    word = ptwa_pkg::CFG_DATA_W'($urandom);
    word[ptwa_pkg::GAIN_W-1:0] = gain;
    write_reg(ptwa_pkg::REG_PH_GAIN, word);
    write_reg(ptwa_pkg::REG_PH_OFFSET, offset);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                ptwa_pkg::CFG_DATA_W'($urandom));
  endtask

  // ring starts at zero, so early windows are full of equal minima
  task automatic test_reset_window();
    send_sample('0);
    send_sample('1);
    send_sample('1);
    send_sample(12'hAAA);
    send_sample(12'h555);
  endtask

  task automatic test_register_writes();
    logic [ptwa_pkg::CFG_DATA_W-1:0] word;
    quiesce();
    word = '1;
    word[ptwa_pkg::GAIN_W-1:0] = ptwa_pkg::GAIN_W'(-60000);
    write_reg(ptwa_pkg::REG_PH_GAIN, word);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, ptwa_pkg::CFG_DATA_W'(12345));
    write_reg(ptwa_pkg::REG_PH_OFFSET, ptwa_pkg::CFG_DATA_W'(-100000000));
    send_sample(12'h7FF);
    send_sample(12'h800);
  endtask

  // zero gain leaves offset / 2^16, so half-step offsets land exactly on ties
  task automatic test_rounding_ties();
    logic [ptwa_pkg::OFFSET_W-1:0] tie_offsets [6];
    tie_offsets = '{ptwa_pkg::OFFSET_W'(32768), ptwa_pkg::OFFSET_W'(-32768),
                    ptwa_pkg::OFFSET_W'(3 * 65536 + 32768),
                    ptwa_pkg::OFFSET_W'(-(3 * 65536 + 32768)), OFFSET_MAX, OFFSET_MIN};
    quiesce();
    write_reg(ptwa_pkg::REG_PH_GAIN, '0);
    foreach (tie_offsets[i]) begin
      quiesce();
      write_reg(ptwa_pkg::REG_PH_OFFSET, tie_offsets[i]);
      send_sample(ptwa_pkg::adc_sample_t'($urandom_range(4095)));
    end
  endtask

  task automatic test_saturation();
    quiesce();
    write_reg(ptwa_pkg::REG_PH_GAIN, GAIN_MAX);
    write_reg(ptwa_pkg::REG_PH_OFFSET, ptwa_pkg::PH_OFFSET_RST);
    send_sample('1);
    send_sample('1);
    quiesce();
    write_reg(ptwa_pkg::REG_PH_GAIN, GAIN_MIN);
    send_sample('1);
  endtask

  task automatic test_random_stream(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned count);
    int unsigned sent;
    int unsigned block_len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < count) begin
      quiesce();
      retune_probe();
      block_len = $urandom_range(30, 120);
      repeat (block_len) begin
        send_sample(draw_sample());
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    ph_reading_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (pending_readings.size() == 0) begin
          $error("result transfer with no sample outstanding");
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          if (result_if.trimmed_sum !== want.trimmed_sum) begin
            $error("trimmed_sum mismatch: expected %0d, got %0d",
                   want.trimmed_sum, result_if.trimmed_sum);
            fail_count++;
          end
          if (result_if.ph_value !== want.ph_value) begin
            $error("ph_value mismatch: expected %0d, got %0d",
                   $signed(want.ph_value), $signed(result_if.ph_value));
            fail_count++;
          end
        end
      end
      result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ph_trimmed_window_average: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_data             <= '0;
    sample_if.valid      <= 1'b0;
    sample_if.adc_sample <= '0;
    src_idle_pct = 22;
    snk_idle_pct = 51;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_window();
    test_register_writes();
    test_rounding_ties();
    test_saturation();
    test_random_stream(22, 51, 600);
    test_random_stream(51, 22, 600);
    test_random_stream(0, 0, 550);

    quiesce();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_ph_trimmed_window_average: done, clean");
    end else begin
      $display("tb_ph_trimmed_window_average: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ptwa_pkg.sv
rtl/core/ptwa_sample_if.sv
rtl/core/ptwa_result_if.sv
rtl/core/ph_trimmed_window_average.sv
sim/tb_ph_trimmed_window_average.sv
